>>> hdl/dtq_pkg.sv
package dtq_pkg;

    // Field widths fixed by the request and result formats.
    localparam int REQ_W      = 2;
    localparam int SLOT_W     = 4;
    localparam int TIMEOUT_W  = 31;
    localparam int NOW_W      = 40;
    localparam int BUDGET_W   = 32;
    localparam int WAIT_W     = 32;
    localparam int DEADLINE_W = 41;
    localparam int ORDER_W    = 32;

    // Largest wait that can be reported.
    localparam logic [WAIT_W-2:0] WAIT_MAX = '1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ARM    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DISARM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

    // Result kinds.
    localparam logic KIND_EXPIRY = 1'b0;
    localparam logic KIND_WAIT   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_EMIT,
        ST_QSCAN,
        ST_QCALC,
        ST_QOUT
    } dtq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic arm_wr;
        logic disarm_wr;
        logic capture;
        logic scan_start;
        logic scan_run;
        logic q_calc;
        logic load_exp;
        logic load_query;
    } dtq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic exp_any;
        logic exp_last;
        logic out_free;
    } dtq_status_t;

endpackage

>>> hdl/dtq_ctrl.sv
module dtq_ctrl
    import dtq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [REQ_W-1:0]     req_type,
    input  dtq_status_t          status,
    output dtq_cmd_t             cmd
);

    dtq_state_t state_reg;
    dtq_state_t state_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_TICK:  state_next = ST_TSCAN;
                        REQ_QUERY: state_next = ST_QSCAN;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_TSCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = status.exp_any ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.exp_last ? ST_IDLE : ST_TSCAN;
                end
            end
            ST_QSCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_QCALC;
                end
            end
            ST_QCALC:
            begin
                state_next = ST_QOUT;
            end
            ST_QOUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_ARM:    cmd.arm_wr    = 1'b1;
                        REQ_DISARM: cmd.disarm_wr = 1'b1;
                        REQ_TICK:
                        begin
                            cmd.capture    = 1'b1;
                            cmd.scan_start = 1'b1;
                        end
                        REQ_QUERY:
                        begin
                            cmd.capture    = 1'b1;
                            cmd.scan_start = 1'b1;
                        end
                        default:    cmd = '0;
                    endcase
                end
            end
            ST_TSCAN, ST_QSCAN:
            begin
                cmd.scan_run = 1'b1;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_exp   = 1'b1;
                    cmd.scan_start = !status.exp_last;
                end
            end
            ST_QCALC:
            begin
                cmd.q_calc = 1'b1;
            end
            ST_QOUT:
            begin
                cmd.load_query = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/dtq_datapath.sv
module dtq_datapath
    import dtq_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [SLOT_W-1:0]           slot,
    input  logic [TIMEOUT_W-1:0]        timeout_ms,
    input  logic [NOW_W-1:0]            now_ms,
    input  logic signed [BUDGET_W-1:0]  budget_ms,
    input  dtq_cmd_t                    cmd,
    output dtq_status_t                 status,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic                        kind,
    output logic [SLOT_W-1:0]           expired_slot,
    output logic signed [WAIT_W-1:0]    wait_ms,
    output logic                        last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int AW = ((IW > SLOT_W) ? IW : SLOT_W) + 1;

    // Deadline and arming order per slot; only used where the slot is armed.
    logic [DEADLINE_W-1:0] deadline_mem [NUM_SLOTS];
    logic [ORDER_W-1:0]    order_mem    [NUM_SLOTS];

    logic [NUM_SLOTS-1:0]  armed_reg, armed_next;
    logic [ORDER_W-1:0]    arm_cnt_reg, arm_cnt_next;

    logic [IW:0]           idx_reg;
    logic                  rd_valid_reg;
    logic [IW-1:0]         rd_idx_reg;
    logic                  rd_armed_reg;
    logic [DEADLINE_W-1:0] rd_deadline_reg;
    logic [ORDER_W-1:0]    rd_order_reg;

    logic                  best_valid_reg;
    logic [IW-1:0]         best_idx_reg;
    logic [DEADLINE_W-1:0] best_deadline_reg;
    logic [ORDER_W-1:0]    best_order_reg;
    logic [CW-1:0]         exp_cnt_reg;

    logic [NOW_W-1:0]      now_reg;
    logic [BUDGET_W-1:0]   budget_reg;
    logic [WAIT_W-2:0]     wait_reg;
    logic                  have_reg;

    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [SLOT_W-1:0]     expired_slot_reg;
    logic [WAIT_W-1:0]     wait_ms_reg;
    logic                  last_reg;

    logic [AW-1:0]         slot_ext;
    logic                  slot_ok;
    logic [IW-1:0]         waddr;
    logic                  issue;
    logic                  rd_hit;
    logic                  rd_first;
    logic                  rd_expired;
    logic [DEADLINE_W-1:0] now_ext;
    logic [DEADLINE_W-1:0] diff;
    logic [WAIT_W-2:0]     wait_calc;
    logic [AW-1:0]         best_ext;
    logic                  use_budget;
    logic [WAIT_W-2:0]     q_wait;
    logic                  q_have;
    logic                  out_load;

    assign slot_ext = AW'(slot);
    assign slot_ok  = slot_ext < AW'(NUM_SLOTS);
    assign waddr    = slot_ext[IW-1:0];
    assign issue    = idx_reg != (IW + 1)'(NUM_SLOTS);
    assign now_ext  = DEADLINE_W'(now_reg);

    assign rd_hit     = rd_valid_reg && rd_armed_reg;
    assign rd_first   = !best_valid_reg
                        || (rd_deadline_reg < best_deadline_reg)
                        || ((rd_deadline_reg == best_deadline_reg)
                            && (rd_order_reg < best_order_reg));
    assign rd_expired = rd_deadline_reg <= now_ext;

    assign arm_cnt_next = arm_cnt_reg + ORDER_W'(1);

    always_comb
    begin
        armed_next = armed_reg;
        if (cmd.arm_wr && slot_ok)
        begin
            armed_next[waddr] = 1'b1;
        end
        if (cmd.disarm_wr && slot_ok)
        begin
            armed_next[waddr] = 1'b0;
        end
        if (cmd.load_exp)
        begin
            armed_next[best_idx_reg] = 1'b0;
        end
    end

    // Memory write on arm, registered read during a scan.
    always_ff @(posedge clk)
    begin
        if (cmd.arm_wr && slot_ok)
        begin
            deadline_mem[waddr] <= DEADLINE_W'(now_ms) + DEADLINE_W'(timeout_ms);
            order_mem[waddr]    <= arm_cnt_next;
        end
        if (cmd.scan_run && issue)
        begin
            rd_deadline_reg <= deadline_mem[idx_reg[IW-1:0]];
            rd_order_reg    <= order_mem[idx_reg[IW-1:0]];
            rd_armed_reg    <= armed_reg[idx_reg[IW-1:0]];
            rd_idx_reg      <= idx_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= '0;
            arm_cnt_reg    <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            exp_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            armed_reg <= armed_next;
            if (cmd.arm_wr && slot_ok)
            begin
                arm_cnt_reg <= arm_cnt_next;
            end

            if (cmd.scan_start)
            begin
                idx_reg        <= '0;
                rd_valid_reg   <= 1'b0;
                best_valid_reg <= 1'b0;
                exp_cnt_reg    <= '0;
            end
            else if (cmd.scan_run)
            begin
                if (issue)
                begin
                    idx_reg <= idx_reg + (IW + 1)'(1);
                end
                rd_valid_reg <= issue;
                if (rd_hit)
                begin
                    if (rd_first)
                    begin
                        best_valid_reg <= 1'b1;
                    end
                    if (rd_expired)
                    begin
                        exp_cnt_reg <= exp_cnt_reg + CW'(1);
                    end
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Running best candidate of the scan, and the time and budget captured with a tick or query.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_run && rd_hit && rd_first)
        begin
            best_idx_reg      <= rd_idx_reg;
            best_deadline_reg <= rd_deadline_reg;
            best_order_reg    <= rd_order_reg;
        end
        if (cmd.capture)
        begin
            now_reg    <= now_ms;
            budget_reg <= budget_ms;
        end
    end

    // Wait to the earliest deadline, floored at zero and saturated.
    assign diff = best_deadline_reg - now_ext;

    always_comb
    begin
        wait_calc = '0;
        if (best_deadline_reg > now_ext)
        begin
            if (diff > DEADLINE_W'(WAIT_MAX))
            begin
                wait_calc = WAIT_MAX;
            end
            else
            begin
                wait_calc = diff[WAIT_W-2:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_calc)
        begin
            wait_reg <= wait_calc;
            have_reg <= best_valid_reg;
        end
    end

    // A non-negative budget caps the wait, or stands in when nothing is armed.
    assign use_budget = !budget_reg[BUDGET_W-1]
                        && (!have_reg || (budget_reg[BUDGET_W-2:0] < wait_reg));
    assign q_wait     = use_budget ? budget_reg[BUDGET_W-2:0] : wait_reg;
    assign q_have     = use_budget || have_reg;

    assign best_ext = AW'(best_idx_reg);
    assign out_load = cmd.load_exp || cmd.load_query;

    always_ff @(posedge clk)
    begin
        if (cmd.load_exp)
        begin
            kind_reg         <= KIND_EXPIRY;
            expired_slot_reg <= best_ext[SLOT_W-1:0];
            wait_ms_reg      <= '0;
            last_reg         <= (exp_cnt_reg == CW'(1));
        end
        else if (cmd.load_query)
        begin
            kind_reg         <= KIND_WAIT;
            expired_slot_reg <= '0;
            wait_ms_reg      <= q_have ? {1'b0, q_wait} : '1;
            last_reg         <= 1'b1;
        end
    end

    assign status.scan_done = !issue && !rd_valid_reg;
    assign status.exp_any   = exp_cnt_reg != '0;
    assign status.exp_last  = exp_cnt_reg == CW'(1);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign expired_slot = expired_slot_reg;
    assign wait_ms      = wait_ms_reg;
    assign last         = last_reg;

endmodule

>>> hdl/deadline_timer_queue.sv
// Deadline timer queue: a table of NUM_SLOTS timer slots with earliest-first expiry.
// The input channel (in_valid, in_stall) carries one request per transfer: arm a slot
// with now_ms + timeout_ms, disarm a slot, tick (expire everything due at now_ms),
// or query the wait until the earliest deadline, optionally capped by budget_ms.
// The output channel (out_valid, out_stall) carries one result per transfer; the last
// result caused by a request has last set.
// Arm and disarm complete in the transfer cycle and produce no result; the block stays
// ready for the next request in the following cycle.
// Tick and query each run a scan over the slot memory, one slot per cycle through its
// single registered read port. A tick that expires k slots rescans after each report
// and is held up by any output stalls; a tick with nothing due gives no result.
// in_stall is high for the whole of that work.
// Results sit in an output register, so once the final result is loaded the block takes
// new requests while that result waits. When the receiver stalls, the result holds
// and a tick with more expiries pauses until the register frees up.
// Reset disarms every slot, clears the arming sequence counter and empties the output.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [REQ_W-1:0]            req_type,
    input  logic [SLOT_W-1:0]           slot,
    input  logic [TIMEOUT_W-1:0]        timeout_ms,
    input  logic [NOW_W-1:0]            now_ms,
    input  logic signed [BUDGET_W-1:0]  budget_ms,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [SLOT_W-1:0]           expired_slot,
    output logic signed [WAIT_W-1:0]    wait_ms,
    output logic                        last
);

    dtq_cmd_t    cmd;
    dtq_status_t status;

    // The controller sequences scans, reports and the query arithmetic.
    dtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the slot table, the scan comparator and the output register.
    dtq_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .slot         (slot),
        .timeout_ms   (timeout_ms),
        .now_ms       (now_ms),
        .budget_ms    (budget_ms),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .kind         (kind),
        .expired_slot (expired_slot),
        .wait_ms      (wait_ms),
        .last         (last)
    );

endmodule

>>> hdl/dtq_checker.sv
module dtq_checker
    import dtq_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic [REQ_W-1:0]            req_type,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        kind,
    input logic [SLOT_W-1:0]           expired_slot,
    input logic signed [WAIT_W-1:0]    wait_ms,
    input logic                        last
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({kind, expired_slot, wait_ms, last}))
        else $error("stalled result changed");

    // A query answer is a single, final result with no slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_WAIT) |-> last && (expired_slot == '0))
        else $error("query answer malformed");

    // An expiry report carries no wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EXPIRY) |-> (wait_ms == '0))
        else $error("expiry report carries a wait");

    // Tick and query keep the input stalled while the scan runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((req_type == REQ_TICK) || (req_type == REQ_QUERY))
            |=> in_stall)
        else $error("request taken during a scan");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);

>>> tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_ITEMS = 250;
    localparam int DIRECTED_N   = 23;

    // A budget or a wait of all ones means "no cap" on the way in and
    // "nothing armed" on the way out.
    localparam logic signed [BUDGET_W-1:0] NO_CAP    = -1;
    localparam logic signed [WAIT_W-1:0]   WAIT_NONE = -1;
    localparam logic signed [BUDGET_W-1:0] CAP_TOP   = 32'sh7FFF_FFFF;
    localparam logic signed [BUDGET_W-1:0] CAP_NEG   = 32'sh8000_0000;
    localparam logic [NOW_W-1:0]           NOW_TOP   = '1;
    localparam logic [TIMEOUT_W-1:0]       TMO_TOP   = '1;

    // One request as the sender sees it. A pinned row carries a wait that
    // is obvious by inspection; it replaces the predicted query answer.
    typedef struct {
        logic [REQ_W-1:0]           op;
        logic [SLOT_W-1:0]          idx;
        logic [TIMEOUT_W-1:0]       tmo;
        logic [NOW_W-1:0]           at;
        logic signed [BUDGET_W-1:0] cap;
        bit                         pinned;
        logic signed [WAIT_W-1:0]   pinned_wait;
    } timer_req_t;

    typedef struct {
        logic                     kind;
        logic [SLOT_W-1:0]        slot;
        logic signed [WAIT_W-1:0] wait_len;
        logic                     last;
    } timer_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [REQ_W-1:0]           req_type;
    logic [SLOT_W-1:0]          slot;
    logic [TIMEOUT_W-1:0]       timeout_ms;
    logic [NOW_W-1:0]           now_ms;
    logic signed [BUDGET_W-1:0] budget_ms;
    logic                       out_valid;
    logic                       out_stall;
    logic                       kind;
    logic [SLOT_W-1:0]          expired_slot;
    logic signed [WAIT_W-1:0]   wait_ms;
    logic                       last;

    deadline_timer_queue #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .slot(slot),
        .timeout_ms(timeout_ms),
        .now_ms(now_ms),
        .budget_ms(budget_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .expired_slot(expired_slot),
        .wait_ms(wait_ms),
        .last(last)
    );

    // Shadow copy of the slot table. It is advanced at the moment each
    // request transfer is accepted, so it always matches what the block
    // has been told so far.
    logic [DEADLINE_W-1:0] slot_due [NUM_SLOTS];
    bit                    slot_live [NUM_SLOTS];
    logic [ORDER_W-1:0]    slot_seq [NUM_SLOTS];
    logic [ORDER_W-1:0]    arm_seq;

    // Results the block still owes us, oldest first.
    timer_result_t timer_results_due[$];

    int  fault_count = 0;
    int  rx_hold = 0;
    bit  no_idle;
    timer_result_t head;

    // Directed requests. The first rows probe an empty table, where every
    // query answer follows from the budget alone. Later rows cover a deadline
    // at the top of the range, above the 40-bit time range, a tie on the deadline broken by
    // arming order, re-arming a slot, disarming an idle slot and a query that
    // finds its deadline already in the past.
    timer_req_t directed_reqs [DIRECTED_N] = '{
        '{REQ_QUERY,  4'd0,  31'd0,   40'd0,   NO_CAP,  1'b1, WAIT_NONE},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd0,   32'sd0,  1'b1, 32'sd0},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd0,   CAP_TOP, 1'b1, CAP_TOP},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd0,   CAP_NEG, 1'b1, WAIT_NONE},
        '{REQ_TICK,   4'd0,  31'd0,   NOW_TOP, NO_CAP,  1'b0, 32'sd0},
        '{REQ_DISARM, 4'd9,  31'd0,   40'd0,   NO_CAP,  1'b0, 32'sd0},
        '{REQ_ARM,    4'd0,  TMO_TOP, NOW_TOP, NO_CAP,  1'b0, 32'sd0},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd0,   NO_CAP,  1'b1, CAP_TOP},
        '{REQ_ARM,    4'd15, 31'd0,   40'd100, NO_CAP,  1'b0, 32'sd0},
        '{REQ_ARM,    4'd3,  31'd60,  40'd40,  NO_CAP,  1'b0, 32'sd0},
        '{REQ_ARM,    4'd7,  31'd30,  40'd90,  NO_CAP,  1'b0, 32'sd0},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd70,  NO_CAP,  1'b0, 32'sd0},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd70,  32'sd10, 1'b0, 32'sd0},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd500, NO_CAP,  1'b0, 32'sd0},
        '{REQ_TICK,   4'd0,  31'd0,   40'd99,  NO_CAP,  1'b0, 32'sd0},
        '{REQ_TICK,   4'd0,  31'd0,   40'd100, NO_CAP,  1'b0, 32'sd0},
        '{REQ_ARM,    4'd15, 31'd5,   40'd100, NO_CAP,  1'b0, 32'sd0},
        '{REQ_ARM,    4'd15, 31'd1,   40'd100, NO_CAP,  1'b0, 32'sd0},
        '{REQ_DISARM, 4'd7,  31'd0,   40'd0,   NO_CAP,  1'b0, 32'sd0},
        '{REQ_TICK,   4'd0,  31'd0,   40'd200, NO_CAP,  1'b0, 32'sd0},
        '{REQ_DISARM, 4'd0,  31'd0,   40'd0,   NO_CAP,  1'b0, 32'sd0},
        '{REQ_QUERY,  4'd0,  31'd0,   40'd0,   NO_CAP,  1'b1, WAIT_NONE},
        '{REQ_TICK,   4'd0,  31'd0,   NOW_TOP, NO_CAP,  1'b0, 32'sd0}
    };

    // Index of the armed slot that expires first, or -1 when none is armed.
    // Equal deadlines go to the smaller arming sequence number.
    function automatic int earliest_live_slot();
        int pick;
        pick = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_live[i] && (pick < 0 || slot_due[i] < slot_due[pick] ||
                (slot_due[i] == slot_due[pick] && slot_seq[i] < slot_seq[pick])))
                pick = i;
        return pick;
    endfunction

    // Adds one result to the tail of the owed list.
    function automatic void owe_result(input timer_result_t res);
        timer_results_due.insert(timer_results_due.size(), res);
    endfunction

    // Applies one request to the shadow table and lists the results it causes.
    function automatic void advance_timer_table(input timer_req_t r,
                                                ref timer_result_t outs[$]);
        int                    first;
        bit                    have;
        logic [DEADLINE_W-1:0] now_x;
        logic [DEADLINE_W-1:0] span;
        logic [DEADLINE_W-1:0] cap_x;
        timer_result_t         res;
        now_x = {1'b0, r.at};
        cap_x = {{(DEADLINE_W-BUDGET_W){1'b0}}, r.cap};
        outs.delete();
        case (r.op)
            REQ_ARM:
            begin
                arm_seq = arm_seq + 1'b1;
                slot_due[r.idx] = now_x + DEADLINE_W'(r.tmo);
                slot_live[r.idx] = 1'b1;
                slot_seq[r.idx] = arm_seq;
            end
            REQ_DISARM:
            begin
                slot_live[r.idx] = 1'b0;
            end
            REQ_TICK:
            begin
                first = earliest_live_slot();
                while (first >= 0 && slot_due[first] <= now_x)
                begin
                    slot_live[first] = 1'b0;
                    res = '{KIND_EXPIRY, SLOT_W'(first), '0, 1'b0};
                    outs.insert(outs.size(), res);
                    first = earliest_live_slot();
                end
                if (outs.size() > 0)
                    outs[outs.size()-1].last = 1'b1;
            end
            default:
            begin
                first = earliest_live_slot();
                have = (first >= 0);
                span = '0;
                if (have && slot_due[first] > now_x)
                begin
                    span = slot_due[first] - now_x;
                    if (span > DEADLINE_W'(WAIT_MAX))
                        span = DEADLINE_W'(WAIT_MAX);
                end
                if (!r.cap[BUDGET_W-1] && (!have || cap_x < span))
                begin
                    span = cap_x;
                    have = 1'b1;
                end
                res = '{KIND_WAIT, '0, have ? WAIT_W'(span) : WAIT_NONE, 1'b1};
                outs.insert(outs.size(), res);
            end
        endcase
    endfunction

    // Presents one request after a random gap and holds it until the block
    // takes it. Valid is only lowered when a gap follows, so back-to-back
    // transfers keep it high without a glitch inside one time step.
    task automatic issue_request(input timer_req_t r);
        int            gap;
        timer_result_t outs[$];
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= r.op;
        slot       <= r.idx;
        timeout_ms <= r.tmo;
        now_ms     <= r.at;
        budget_ms  <= r.cap;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_timer_table(r, outs);
        if (r.pinned)
            owe_result('{KIND_WAIT, '0, r.pinned_wait, 1'b1});
        else
            foreach (outs[k])
                owe_result(outs[k]);
    endtask

    // Stops sending and waits until every owed result has been taken.
    task automatic hold_until_settled();
        in_valid <= 1'b0;
        @(posedge clk);
        while (timer_results_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or never delivers a result.
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side. Every accepted transfer is matched against the oldest
    // owed result. The stall may be raised after a transfer, and
    // is also raised now and then while idle so that it lands on every phase
    // of the block's scan, not only right behind a result.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (timer_results_due.size() == 0)
            begin
                $error("result with nothing owed: kind %0d slot %0d wait %0d last %0d",
                       kind, expired_slot, wait_ms, last);
                fault_count++;
            end
            else
            begin
                head = timer_results_due.pop_front();
                if (kind !== head.kind)
                begin
                    $error("kind: expected %0d, got %0d", head.kind, kind);
                    fault_count++;
                end
                if (expired_slot !== head.slot)
                begin
                    $error("expired_slot: expected %0d, got %0d", head.slot, expired_slot);
                    fault_count++;
                end
                if (wait_ms !== head.wait_len)
                begin
                    $error("wait_ms: expected %0d, got %0d", head.wait_len, wait_ms);
                    fault_count++;
                end
                if (last !== head.last)
                begin
                    $error("last: expected %0d, got %0d", head.last, last);
                    fault_count++;
                end
            end
            rx_hold = no_idle ? 0 : $urandom_range(0, 4);
        end
        else if (rx_hold > 0)
            rx_hold--;
        else if (!no_idle && $urandom_range(0, 7) == 0)
            rx_hold = $urandom_range(1, 4);
        out_stall <= (rx_hold > 0);
    end

    initial
    begin : stimulus
        timer_req_t       r;
        logic [NOW_W-1:0] sim_now;
        int               fill_left;
        bit               flush_due;
        int               pick;

        no_idle     = 1'b0;
        arm_seq     = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_due[i]  = '0;
            slot_live[i] = 1'b0;
            slot_seq[i]  = '0;
        end

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= REQ_ARM;
        slot       <= '0;
        timeout_ms <= '0;
        now_ms     <= '0;
        budget_ms  <= NO_CAP;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_reqs[i])
            issue_request(directed_reqs[i]);

        // Let everything drain before the random traffic starts.
        hold_until_settled();

        // Random traffic runs on a loosely advancing clock so that arms and
        // ticks interact. Every eightieth item or so, all slots are armed
        // with short timeouts and then a tick far enough ahead expires the
        // whole table in one burst. A tenth of requests carry an arbitrary
        // time, which includes time running backwards and the top bit of
        // the 40-bit range.
        sim_now   = 40'd1000;
        fill_left = 0;
        flush_due = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                hold_until_settled();
            if (n % 80 == 40)
                fill_left = NUM_SLOTS;
            sim_now += NOW_W'($urandom_range(0, 40));

            r.idx         = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            r.tmo         = TIMEOUT_W'($urandom);
            r.at          = sim_now;
            r.cap         = $urandom;
            r.pinned      = 1'b0;
            r.pinned_wait = '0;
            if (fill_left > 0)
            begin
                fill_left--;
                r.op      = REQ_ARM;
                r.idx     = SLOT_W'(fill_left);
                r.tmo     = TIMEOUT_W'($urandom_range(0, 200));
                flush_due = (fill_left == 0);
            end
            else if (flush_due)
            begin
                flush_due = 1'b0;
                sim_now  += NOW_W'(500);
                r.op      = REQ_TICK;
                r.at      = sim_now;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    r.op = REQ_ARM;
                    if (pick < 38)
                        r.tmo = TIMEOUT_W'($urandom_range(0, 300));
                    else if (pick < 40)
                        r.tmo = '0;
                end
                else if (pick < 55)
                    r.op = REQ_DISARM;
                else if (pick < 80)
                begin
                    r.op = REQ_TICK;
                    if (pick == 79)
                        r.at = NOW_TOP;
                end
                else
                begin
                    r.op = REQ_QUERY;
                    if (pick < 88)
                        r.cap = NO_CAP;
                    else if (pick < 94)
                        r.cap = $urandom_range(0, 500);
                end
                if ($urandom_range(0, 9) == 0)
                    r.at = NOW_W'({$urandom, $urandom});
            end
            issue_request(r);
        end

        hold_until_settled();
        // A late tick scan could still emit a stray result; give it time.
        repeat (4 * (NUM_SLOTS + 4)) @(posedge clk);
        if (fault_count == 0 && timer_results_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> deadline_timer_queue.f
hdl/dtq_pkg.sv
hdl/dtq_ctrl.sv
hdl/dtq_datapath.sv
hdl/deadline_timer_queue.sv
hdl/dtq_checker.sv
tb/testbench.sv
